// ===== design/biquad_cascade_error_feedback_top_assert.svh =====
// Assertion macros used by the checker of the biquad cascade.
// Depends on nothing; each macro expects clk and rst in the scope of its use.
`ifndef BIQUAD_CASCADE_ERROR_FEEDBACK_TOP_ASSERT_SVH
`define BIQUAD_CASCADE_ERROR_FEEDBACK_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define BQEF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BQEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bqef_pkg.sv =====
// Types, codes and the microcode table of the biquad cascade.
// Depends on nothing; used by the top level, the checker and the testbench.
`default_nettype none

package bqef_pkg;

  localparam int COEFS_PER_STAGE = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam int STEP_W = 4;

  localparam logic CMD_COEF = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SHIFT = 1'b1;

  localparam logic [4:0] STAGE_COUNT_RESET = 5'd1;
  localparam logic [4:0] COEF_SHIFT_RESET = 5'd28;

  typedef enum logic [2:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1M,
    COEF_A2
  } coef_sel_t;

  typedef enum logic [2:0] {
    MUL_XLO,
    MUL_XHI,
    MUL_X1,
    MUL_X2,
    MUL_Y1,
    MUL_Y2
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_SEED,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    coef_sel_t coef_sel;
    logic      st_latch;
    logic      mul_en;
    mul_sel_t  mul_sel;
    acc_op_t   acc_op;
    logic      sect_end;
  } ctrl_t;

  typedef struct packed {
    logic [63:0] acc;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] y1;
    logic [31:0] y2;
  } hist_t;

  // One section takes nine steps. The coefficient read issued in a step is
  // consumed by the multiplier in the next step, and the product is added
  // in the step after that.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{coef_sel: COEF_B0, st_latch: 1'b0, mul_en: 1'b0, mul_sel: MUL_XLO,
          acc_op: ACC_HOLD, sect_end: 1'b0};
    case (step)
      4'd0: begin
        c.coef_sel = COEF_B0;
      end
      4'd1: begin
        c.coef_sel = COEF_B0;
        c.st_latch = 1'b1;
        c.mul_en = 1'b1;
        c.mul_sel = MUL_XLO;
        c.acc_op = ACC_SEED;
      end
      4'd2: begin
        c.coef_sel = COEF_B1;
        c.mul_en = 1'b1;
        c.mul_sel = MUL_XHI;
        c.acc_op = ACC_ADD;
      end
      4'd3: begin
        c.coef_sel = COEF_B2;
        c.mul_en = 1'b1;
        c.mul_sel = MUL_X1;
        c.acc_op = ACC_ADD;
      end
      4'd4: begin
        c.coef_sel = COEF_A1M;
        c.mul_en = 1'b1;
        c.mul_sel = MUL_X2;
        c.acc_op = ACC_ADD;
      end
      4'd5: begin
        c.coef_sel = COEF_A2;
        c.mul_en = 1'b1;
        c.mul_sel = MUL_Y1;
        c.acc_op = ACC_ADD;
      end
      4'd6: begin
        c.mul_en = 1'b1;
        c.mul_sel = MUL_Y2;
        c.acc_op = ACC_ADD;
      end
      4'd7: begin
        c.acc_op = ACC_ADD;
      end
      4'd8: begin
        c.sect_end = 1'b1;
      end
      default: begin
        c.sect_end = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/bqef_ifaces.sv =====
// Valid/ready channel interfaces for commands in and accumulators out.
// Depends on nothing.
`default_nettype none

interface bqef_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [3:0]         stage_index;
  logic [2:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] sample_in;

  modport source (output valid, command, stage_index, coef_index, coef_value, sample_in,
                  input ready);
  modport sink (input valid, command, stage_index, coef_index, coef_value, sample_in,
                output ready);
endinterface

interface bqef_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] acc_out;

  modport source (output valid, acc_out, input ready);
  modport sink (input valid, acc_out, output ready);
endinterface

`default_nettype wire

// ===== design/bqef_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module bqef_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/biquad_cascade_error_feedback_top.sv =====
// Top level of the biquad cascade with error feedback: microcoded sequencer,
// shared multiplier and the coefficient and section-state RAMs.
// Depends on bqef_pkg, bqef_ifaces and bqef_ram.
//
// Usage: items arrive on req. An item with command zero writes one
// coefficient word into the coefficient RAM in the cycle of its transfer if
// its stage_index and coef_index are in range, and gives no result; the block
// stays ready. An item with command one filters sample_in through stage_count
// sections (clamped to 1..MAX_STAGES) and gives one result on rsp, the last
// section's 64-bit accumulator.
// The sequencer walks one section at a time through a nine-step program
// around a single 33x32 multiplier; the next item can be taken in the cycle
// after the result transfer, and none is taken while a sample is in flight.
// Reset: rst clears the sequencer, sets stage_count to 1 and coef_shift to
// 28, and marks every section's history as zero. Coefficients keep whatever
// the RAM holds and must be written before use.
// Stall: while rsp.ready is low the result holds on rsp and req.ready stays
// low. cfg_we writes the register named by cfg_index and is meant for idle periods.
`default_nettype none

module biquad_cascade_error_feedback_top #(
  parameter int MAX_STAGES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  bqef_req_if.sink                         req,
  bqef_rsp_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [bqef_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bqef_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import bqef_pkg::*;

  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int CDEPTH = MAX_STAGES * COEFS_PER_STAGE;
  localparam int CAW = $clog2(CDEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t              state;
  logic [4:0]          stage_count;
  logic [4:0]          coef_shift;
  logic [STEP_W-1:0]   step;
  logic [SW-1:0]       sec;
  logic [SW-1:0]       last_sec;
  logic [MAX_STAGES-1:0] stage_valid;
  logic [63:0]         xr;
  logic [63:0]         acc;
  logic [63:0]         prod_q;
  hist_t               st;

  ctrl_t               ctrl;
  logic                take;
  logic                coef_we;
  logic [CAW-1:0]      coef_waddr;
  logic [CAW-1:0]      coef_raddr;
  logic [31:0]         coef_rdata;
  hist_t               st_rdata;
  hist_t               st_cur;
  hist_t               st_wdata;
  logic                st_we;
  logic signed [32:0]  mul_a;
  logic signed [64:0]  prod;
  logic [63:0]         prod_next;
  logic [63:0]         y_next;
  logic [SW-1:0]       last_sec_next;
  int                  n_req;

  assign ctrl = ucode(step);
  assign take = req.valid && req.ready;

  assign coef_we = take && (req.command == CMD_COEF)
                   && (int'(req.stage_index) < MAX_STAGES)
                   && (int'(req.coef_index) < COEFS_PER_STAGE);
  assign coef_waddr = CAW'(int'(req.stage_index) * COEFS_PER_STAGE + int'(req.coef_index));
  assign coef_raddr = CAW'(int'(sec) * COEFS_PER_STAGE + int'(ctrl.coef_sel));

  bqef_ram #(
    .WIDTH (32),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (req.coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  bqef_ram #(
    .WIDTH ($bits(hist_t)),
    .DEPTH (MAX_STAGES)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (sec),
    .wdata (st_wdata),
    .raddr (sec),
    .rdata (st_rdata)
  );

  always_comb begin
    n_req = int'(stage_count);
    if (n_req < 1) begin
      n_req = 1;
    end
    if (n_req > MAX_STAGES) begin
      n_req = MAX_STAGES;
    end
    last_sec_next = SW'(n_req - 1);
  end

  // A section that was never run reads as all zero.
  assign st_cur = stage_valid[sec] ? st_rdata : '0;

  always_comb begin
    case (ctrl.mul_sel)
      MUL_XLO: mul_a = {1'b0, xr[31:0]};
      MUL_XHI: mul_a = {1'b0, xr[63:32]};
      MUL_X1:  mul_a = {st.x1[31], st.x1};
      MUL_X2:  mul_a = {st.x2[31], st.x2};
      MUL_Y1:  mul_a = {st.y1[31], st.y1};
      MUL_Y2:  mul_a = {st.y2[31], st.y2};
      default: mul_a = '0;
    endcase
  end

  assign prod = mul_a * $signed(coef_rdata);

  // The upper word of the 64-bit input only matters in the low 32 bits of
  // its product, which land in the upper half of the accumulator.
  assign prod_next = (ctrl.mul_sel == MUL_XHI) ? {prod[31:0], 32'h0} : prod[63:0];

  assign y_next = $signed(acc) >>> coef_shift;

  assign st_we = (state == S_RUN) && ctrl.sect_end;
  assign st_wdata = '{acc: acc, x1: xr[31:0], x2: st.x1, y1: y_next[31:0], y2: st.y1};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stage_count <= STAGE_COUNT_RESET;
      coef_shift <= COEF_SHIFT_RESET;
      step <= '0;
      sec <= '0;
      stage_valid <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STAGE_COUNT: stage_count <= cfg_wdata;
          REG_COEF_SHIFT:  coef_shift <= cfg_wdata;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (take && (req.command == CMD_SAMPLE)) begin
            state <= S_RUN;
            step <= '0;
            sec <= '0;
            last_sec <= last_sec_next;
            xr <= {{32{req.sample_in[31]}}, req.sample_in};
          end
        end
        S_RUN: begin
          if (ctrl.mul_en) begin
            prod_q <= prod_next;
          end
          case (ctrl.acc_op)
            ACC_SEED: acc <= st_cur.acc;
            ACC_ADD:  acc <= acc + prod_q;
            default:  ;
          endcase
          if (ctrl.st_latch) begin
            st <= st_cur;
          end
          if (ctrl.sect_end) begin
            stage_valid[sec] <= 1'b1;
            xr <= y_next;
            step <= '0;
            if (sec == last_sec) begin
              state <= S_DONE;
            end else begin
              sec <= sec + 1'b1;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DONE: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);
  assign rsp.acc_out = acc;

endmodule

`default_nettype wire

// ===== design/bqef_checker.sv =====
// Port-level checker for the biquad cascade, bound to the top level.
// Depends on biquad_cascade_error_feedback_top_assert.svh and bqef_pkg.
`default_nettype none

`include "biquad_cascade_error_feedback_top_assert.svh"

module bqef_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_command,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [63:0] acc_out
);

  import bqef_pkg::*;

  logic req_xfer;
  logic rsp_stall;

  assign req_xfer = req_valid && req_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;

  // A stalled result holds its value.
  `BQEF_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(acc_out), "result changed while stalled")
  // A coefficient write never produces a result.
  `BQEF_ASSERT_NEXT(a_coef_silent, req_xfer && (req_command == CMD_COEF), !rsp_valid, "coefficient write produced a result")
  // After a sample transfer the block is busy.
  `BQEF_ASSERT_NEXT(a_busy, req_xfer && (req_command == CMD_SAMPLE), !req_ready, "ready after sample transfer")
  // Only one item is in flight: no input is taken while a result waits.
  `BQEF_ASSERT_NOW(a_one_item, rsp_valid, !req_ready, "ready while result pending")

endmodule

bind biquad_cascade_error_feedback_top bqef_checker u_bqef_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_command (req.command),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .acc_out     (rsp.acc_out)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for biquad_cascade_error_feedback_top: a directed table, then
// random phases of coefficient loads and samples checked against an in-bench filter model.
// Depends on bqef_pkg, bqef_ifaces and the top level of the biquad cascade.
`default_nettype none

module testbench;
  import bqef_pkg::*;

  localparam int STAGES = 16;
  localparam int DRAIN_CYCLES = 9 * STAGES + 16;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int N_DIRECTED = 23;
  localparam logic [2:0] COEF_IDX_SPARE_LO = 3'd5;
  localparam logic [2:0] COEF_IDX_SPARE_HI = 3'd7;

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    logic        command;
    logic [3:0]  stage_index;
    logic [2:0]  coef_index;
    logic [31:0] coef_value;
    logic [31:0] sample_in;
  } item_t;

  typedef struct packed {
    row_kind_t             kind;
    item_t                 it;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    logic                  typed;
    logic [63:0]           typed_acc;
  } row_t;

  localparam item_t NO_ITEM = '0;
  localparam logic [63:0] NO_ACC = '0;

  row_t directed_rows [N_DIRECTED] = '{
    '{ROW_ITEM, '{CMD_COEF, 4'd0, COEF_B0, 32'h1000_0000, 32'd0},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_COEF, 4'd0, COEF_B1, 32'd0, 32'd0}, REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_COEF, 4'd0, COEF_B2, 32'd0, 32'd0}, REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_COEF, 4'd0, COEF_A1M, 32'd0, 32'd0}, REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_COEF, 4'd0, COEF_A2, 32'd0, 32'd0}, REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_COEF, 4'd0, COEF_IDX_SPARE_LO, 32'hFFFF_FFFF, 32'd0},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_COEF, 4'd15, COEF_IDX_SPARE_HI, 32'hFFFF_FFFF, 32'd0},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_SAMPLE, 4'd0, COEF_B0, 32'd0, 32'd1},
      REG_STAGE_COUNT, 5'd0, 1'b1, 64'h0000_0000_1000_0000},
    '{ROW_ITEM, '{CMD_SAMPLE, 4'd0, COEF_B0, 32'd0, 32'd0},
      REG_STAGE_COUNT, 5'd0, 1'b1, 64'h0000_0000_1000_0000},
    '{ROW_ITEM, '{CMD_COEF, 4'd0, COEF_B0, 32'h8000_0000, 32'd0},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_COEF, 4'd0, COEF_B1, 32'h7FFF_FFFF, 32'd0},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_COEF, 4'd0, COEF_B2, 32'hFFFF_FFFF, 32'd0},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_COEF, 4'd0, COEF_A1M, 32'h8000_0000, 32'd0},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_COEF, 4'd0, COEF_A2, 32'h7FFF_FFFF, 32'd0},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_SAMPLE, 4'd0, COEF_B0, 32'd0, 32'h7FFF_FFFF},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_SAMPLE, 4'd0, COEF_B0, 32'd0, 32'h8000_0000},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_REG, NO_ITEM, REG_COEF_SHIFT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_SAMPLE, 4'd0, COEF_B0, 32'd0, 32'hFFFF_FFFF},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_REG, NO_ITEM, REG_COEF_SHIFT, 5'd31, 1'b0, NO_ACC},
    '{ROW_REG, NO_ITEM, REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_SAMPLE, 4'd0, COEF_B0, 32'd0, 32'h7FFF_FFFF},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_SAMPLE, 4'd0, COEF_B0, 32'd0, 32'h8000_0000},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC},
    '{ROW_ITEM, '{CMD_COEF, 4'd15, COEF_B0, 32'h1234_5678, 32'd0},
      REG_STAGE_COUNT, 5'd0, 1'b0, NO_ACC}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bqef_req_if req ();
  bqef_rsp_if rsp ();

  biquad_cascade_error_feedback_top #(
    .MAX_STAGES(STAGES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] coef_mem [STAGES * COEFS_PER_STAGE];
  logic [63:0] acc_mem [STAGES];
  logic [31:0] xd1 [STAGES];
  logic [31:0] xd2 [STAGES];
  logic [31:0] yd1 [STAGES];
  logic [31:0] yd2 [STAGES];
  logic [4:0] cur_stages;
  logic [4:0] cur_shift;

  logic [63:0] acc_expected [$];
  logic [63:0] acc_want;
  int mismatch_count = 0;
  bit quiet = 1'b0;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic void load_coef(input item_t it);
    if (it.coef_index < COEFS_PER_STAGE && it.stage_index < STAGES)
      coef_mem[it.stage_index * COEFS_PER_STAGE + it.coef_index] = it.coef_value;
  endfunction

  function automatic logic [63:0] filter_sample(input logic [31:0] smp);
    logic [63:0] x;
    logic [63:0] acc;
    int nsec;
    int base;
    x = sext32(smp);
    acc = '0;
    nsec = cur_stages;
    if (nsec < 1) nsec = 1;
    if (nsec > STAGES) nsec = STAGES;
    for (int s = 0; s < nsec; s++) begin
      base = s * COEFS_PER_STAGE;
      acc = acc_mem[s];
      acc = acc + x * sext32(coef_mem[base + COEF_B0]);
      acc = acc + sext32(xd1[s]) * sext32(coef_mem[base + COEF_B1]);
      acc = acc + sext32(xd2[s]) * sext32(coef_mem[base + COEF_B2]);
      acc = acc + sext32(yd1[s]) * sext32(coef_mem[base + COEF_A1M]);
      acc = acc + sext32(yd2[s]) * sext32(coef_mem[base + COEF_A2]);
      acc_mem[s] = acc;
      xd2[s] = xd1[s];
      xd1[s] = x[31:0];
      x = $signed(acc) >>> cur_shift;
      yd2[s] = yd1[s];
      yd1[s] = x[31:0];
    end
    return acc;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'd0;
      3, 4, 5: v = $urandom;
      default: begin
        v = $urandom & ((32'd1 << $urandom_range(1, 30)) - 32'd1);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.command = ($urandom_range(0, 99) < 85) ? CMD_SAMPLE : CMD_COEF;
    it.stage_index = 4'($urandom_range(0, STAGES - 1));
    it.coef_index = 3'($urandom_range(0, 7));
    it.coef_value = pick_word();
    it.sample_in = pick_word();
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_item(input item_t it, input logic typed, input logic [63:0] typed_acc);
    int gap;
    logic [63:0] acc;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.command <= it.command;
    req.stage_index <= it.stage_index;
    req.coef_index <= it.coef_index;
    req.coef_value <= it.coef_value;
    req.sample_in <= it.sample_in;
    do @(posedge clk); while (!req.ready);
    if (it.command == CMD_SAMPLE) begin
      acc = filter_sample(it.sample_in);
      acc_expected.push_back(typed ? typed_acc : acc);
    end else begin
      load_coef(it);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req.valid <= 1'b0;
    while (acc_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_STAGE_COUNT) cur_stages = val;
    else cur_shift = val;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (acc_expected.size() == 0) begin
        report_mismatch("unexpected result", rsp.acc_out, NO_ACC);
      end else begin
        acc_want = acc_expected.pop_front();
        if (rsp.acc_out !== acc_want) report_mismatch("acc_out", rsp.acc_out, acc_want);
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        stall--;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    #15_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int phase_stages [5];
    int phase_shift [5];
    item_t it;
    logic [4:0] stages;
    logic [4:0] shift;
    phase_stages = '{1, 16, 31, 0, 8};
    phase_shift = '{28, 31, 0, 14, 30};
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_STAGE_COUNT;
    cfg_wdata <= '0;
    req.valid <= 1'b0;
    req.command <= CMD_COEF;
    req.stage_index <= '0;
    req.coef_index <= '0;
    req.coef_value <= '0;
    req.sample_in <= '0;
    for (int i = 0; i < STAGES * COEFS_PER_STAGE; i++) coef_mem[i] = '0;
    for (int s = 0; s < STAGES; s++) begin
      acc_mem[s] = '0;
      xd1[s] = '0;
      xd2[s] = '0;
      yd1[s] = '0;
      yd2[s] = '0;
    end
    cur_stages = STAGE_COUNT_RESET;
    cur_shift = COEF_SHIFT_RESET;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].kind == ROW_REG)
        set_reg(directed_rows[r].reg_index, directed_rows[r].reg_value);
      else
        push_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].typed_acc);
    end

    // Every coefficient of every section is loaded before any deeper cascade runs.
    for (int s = 0; s < STAGES; s++) begin
      for (int c = 0; c < COEFS_PER_STAGE; c++) begin
        it = random_item();
        it.command = CMD_COEF;
        it.stage_index = 4'(s);
        it.coef_index = 3'(c);
        push_item(it, 1'b0, NO_ACC);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      stages = (p < 5) ? 5'(phase_stages[p]) : 5'($urandom_range(0, 31));
      shift = (p < 5) ? 5'(phase_shift[p]) : 5'($urandom_range(0, 31));
      set_reg(REG_STAGE_COUNT, stages);
      set_reg(REG_COEF_SHIFT, shift);
      quiet = (p == 3) || (p == 7);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) push_item(random_item(), 1'b0, NO_ACC);
    end
    quiet = 1'b0;

    wait_idle();
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== biquad_cascade_error_feedback_top.f =====
+incdir+design
design/bqef_pkg.sv
design/bqef_ifaces.sv
design/bqef_ram.sv
design/biquad_cascade_error_feedback_top.sv
design/bqef_checker.sv
tb/testbench.sv
